// File: rtl/led_blink_breath_controller_defines.svh
// ============================================================================
// led_blink_breath_controller_defines
// Assertion macros for the LED blink/breath controller.
// ============================================================================
`ifndef LED_BLINK_BREATH_CONTROLLER_DEFINES_SVH
`define LED_BLINK_BREATH_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
// a holds -> b holds in the same cycle
`define LBB_ASSERT_IMPL(lbl, ck, rn, a, b) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
        else $error("implication check failed");
// a holds -> b holds in the next cycle
`define LBB_ASSERT_NEXT(lbl, ck, rn, a, b) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define LBB_ASSERT_IMPL(lbl, ck, rn, a, b)
`define LBB_ASSERT_NEXT(lbl, ck, rn, a, b)
`endif
`endif

// File: rtl/lbb_pkg.sv
// ============================================================================
// lbb_pkg
// Shared constants, types and the sin^2 table for the LED controller.
// ============================================================================
`default_nettype none
package lbb_pkg;

    localparam int NUM_LEDS         = 4;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int LED_W            = 2;
    localparam int TBL_W            = $clog2(SINE_TABLE_DEPTH);
    localparam int DIVD_W           = 24 + TBL_W;
    localparam int DIVS_W           = 24;
    localparam int SQ_W             = 17;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_ON     = 3'd1;
    localparam logic [2:0] OP_OFF    = 3'd2;
    localparam logic [2:0] OP_TOGGLE = 3'd3;
    localparam logic [2:0] OP_LOAD   = 3'd4;

    localparam logic [1:0] MODE_STATIC = 2'd0;
    localparam logic [1:0] MODE_BLINK  = 2'd1;
    localparam logic [1:0] MODE_BREATH = 2'd2;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_POL    = 3'd1;
    localparam logic [2:0] REG_ON     = 3'd2;
    localparam logic [2:0] REG_OFF    = 3'd3;
    localparam logic [2:0] REG_BREATH = 3'd4;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] TAYLOR_DIV [1:6] = '{64'd6, 64'd20, 64'd42,
                                                 64'd72, 64'd110, 64'd156};

    typedef logic [SQ_W-1:0] sq_tab_t [SINE_TABLE_DEPTH];

    // Q30 Taylor sine on the folded angle, squared to Q16
    function automatic logic [SQ_W-1:0] sin_sq(input int i);
        logic [63:0] j, x, x2, term, sum, sq;
        j = 64'(i);
        if (2 * j > 64'(SINE_TABLE_DEPTH))
            j = 64'(SINE_TABLE_DEPTH) - j;
        x = (PI_Q30 * j) / SINE_TABLE_DEPTH;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int k = 1; k <= 6; k++)
        begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[k];
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        if (sum > ONE_Q30)
            sum = ONE_Q30;
        sq = (sum * sum + (64'd1 << 43)) >> 44;
        if (sq > 64'd65536)
            sq = 64'd65536;
        return sq[SQ_W-1:0];
    endfunction

    function automatic sq_tab_t build_sq_table();
        sq_tab_t t;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
            t[i] = sin_sq(i);
        return t;
    endfunction

    localparam sq_tab_t SQ_TABLE = build_sq_table();

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch accepted item
        logic exec;      // apply opcode / blink step
        logic div_start;
        logic div_sel;   // 0: breath ticks / period, 1: step*depth / M
        logic cap_m;
        logic cap_idx;
        logic mul;
        logic wb;        // write breath on/off/step
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic breath_go;
        logic div_busy;
        logic div_done;
        logic m_zero;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// File: rtl/lbb_divider.sv
// ============================================================================
// lbb_divider
// Restoring divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none
module lbb_divider (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [lbb_pkg::DIVD_W-1:0] dividend,
    input  wire logic [lbb_pkg::DIVS_W-1:0] divisor,
    output logic                           busy,
    output logic                           done,
    output logic [lbb_pkg::DIVD_W-1:0]     quotient
);
    localparam int CNT_W = $clog2(lbb_pkg::DIVD_W + 1);

    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        done_reg, done_next;
    logic [lbb_pkg::DIVD_W-1:0]  q_reg, q_next;
    logic [lbb_pkg::DIVS_W-1:0]  rem_reg, rem_next, dvs_reg, dvs_next;
    logic [lbb_pkg::DIVS_W:0]    rem_shift;

    always_comb
    begin
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        rem_shift = {rem_reg, q_reg[lbb_pkg::DIVD_W-1]};
        if (start)
        begin
            cnt_next = CNT_W'(lbb_pkg::DIVD_W);
            q_next   = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (rem_shift >= {1'b0, dvs_reg})
            begin
                rem_next = lbb_pkg::DIVS_W'(rem_shift - {1'b0, dvs_reg});
                q_next   = {q_reg[lbb_pkg::DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[lbb_pkg::DIVS_W-1:0];
                q_next   = {q_reg[lbb_pkg::DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = (cnt_reg != '0);
    assign done     = done_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire

// File: rtl/lbb_datapath.sv
// ============================================================================
// lbb_datapath
// Per-LED state, blink step, breath arithmetic and result register.
// ============================================================================
`default_nettype none
module lbb_datapath (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire lbb_pkg::cmd_t             cmd,
    output lbb_pkg::stat_t                 stat,
    input  wire logic [2:0]                opcode,
    input  wire logic [lbb_pkg::LED_W-1:0] led_index,
    input  wire logic [1:0]                cfg_mode,
    input  wire logic                      cfg_pol,
    input  wire logic [15:0]               cfg_on,
    input  wire logic [15:0]               cfg_off,
    input  wire logic [23:0]               cfg_breath,
    input  wire logic                      out_stall,
    output logic                           out_valid,
    output logic [lbb_pkg::LED_W-1:0]      led_sel,
    output logic                           pin_level,
    output logic                           lit
);
    localparam int N = lbb_pkg::NUM_LEDS;

    logic [1:0]  mode_reg [N];
    logic        pol_reg  [N];
    logic        lit_reg  [N];
    logic [16:0] tc_reg   [N];
    logic [15:0] onl_reg  [N];
    logic [15:0] offl_reg [N];
    logic [23:0] bps_reg  [N];
    logic [23:0] step_reg [N];

    logic [2:0]                op_reg;
    logic [lbb_pkg::LED_W-1:0] n_reg;
    logic                      nv_reg;
    logic [16:0]               per_reg;
    logic [23:0]               m_reg;
    logic [lbb_pkg::TBL_W-1:0] tidx_reg;
    logic [33:0]               prod_reg;
    logic                      ov_reg;
    logic [lbb_pkg::LED_W-1:0] osel_reg;
    logic                      opin_reg, olit_reg;

    logic [16:0] total, tc_inc, tc_new;
    logic        lit_blink;
    logic        ticking;
    logic [17:0] on_raw;
    logic [15:0] on_sat, off_sat;
    logic [16:0] off_raw;
    logic [24:0] step_inc;
    logic [lbb_pkg::DIVD_W-1:0] dvd;
    logic [lbb_pkg::DIVS_W-1:0] dvs;
    logic [lbb_pkg::DIVD_W-1:0] quot;
    logic div_busy, div_done;

    assign total  = {1'b0, onl_reg[n_reg]} + {1'b0, offl_reg[n_reg]};
    assign tc_inc = tc_reg[n_reg] + 17'd1;
    assign tc_new = (tc_inc >= total) ? 17'd0 : tc_inc;

    always_comb
    begin
        lit_blink = lit_reg[n_reg];
        if ({1'b0, tc_reg[n_reg]} < {2'b0, onl_reg[n_reg]})
            lit_blink = 1'b1;
        else if (tc_reg[n_reg] <= total)
            lit_blink = 1'b0;
    end

    assign ticking = nv_reg && (op_reg == lbb_pkg::OP_TICK) &&
                     ((mode_reg[n_reg] == lbb_pkg::MODE_BLINK) ||
                      (mode_reg[n_reg] == lbb_pkg::MODE_BREATH));

    // breath arithmetic
    assign on_raw   = prod_reg[33:16];
    assign on_sat   = (on_raw > 18'd65535) ? 16'hFFFF : on_raw[15:0];
    assign off_raw  = per_reg - {1'b0, on_sat};
    assign off_sat  = off_raw[16] ? 16'hFFFF : off_raw[15:0];
    assign step_inc = {1'b0, step_reg[n_reg]} + 25'd1;

    assign dvd = cmd.div_sel ? {step_reg[n_reg], lbb_pkg::TBL_W'(0)}
                             : lbb_pkg::DIVD_W'(bps_reg[n_reg]);
    assign dvs = cmd.div_sel ? m_reg : lbb_pkg::DIVS_W'(per_reg);

    lbb_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                mode_reg[i] <= lbb_pkg::MODE_STATIC;
                pol_reg[i]  <= 1'b0;
                lit_reg[i]  <= 1'b0;
                tc_reg[i]   <= '0;
                onl_reg[i]  <= '0;
                offl_reg[i] <= '0;
                bps_reg[i]  <= '0;
                step_reg[i] <= '0;
            end
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec && nv_reg)
            begin
                case (op_reg)
                    lbb_pkg::OP_TICK:
                    begin
                        if (ticking)
                        begin
                            lit_reg[n_reg] <= lit_blink;
                            tc_reg[n_reg]  <= tc_new;
                        end
                    end
                    lbb_pkg::OP_ON:     lit_reg[n_reg] <= 1'b1;
                    lbb_pkg::OP_OFF:    lit_reg[n_reg] <= 1'b0;
                    lbb_pkg::OP_TOGGLE: lit_reg[n_reg] <= ~lit_reg[n_reg];
                    lbb_pkg::OP_LOAD:
                    begin
                        mode_reg[n_reg] <= cfg_mode;
                        pol_reg[n_reg]  <= cfg_pol;
                        onl_reg[n_reg]  <= cfg_on;
                        offl_reg[n_reg] <= cfg_off;
                        bps_reg[n_reg]  <= cfg_breath;
                        tc_reg[n_reg]   <= '0;
                        step_reg[n_reg] <= '0;
                    end
                    default: ;
                endcase
            end
            if (cmd.wb)
            begin
                onl_reg[n_reg]  <= on_sat;
                offl_reg[n_reg] <= off_sat;
                step_reg[n_reg] <= (step_inc >= {1'b0, m_reg}) ? 24'd0
                                                               : step_inc[23:0];
            end
            if (cmd.out_load)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= opcode;
            n_reg  <= led_index;
            nv_reg <= ({1'b0, led_index} < (lbb_pkg::LED_W + 1)'(N));
        end
        if (cmd.exec)
            per_reg <= total;
        if (cmd.cap_m)
            m_reg <= quot[23:0];
        if (cmd.cap_idx)
            tidx_reg <= quot[lbb_pkg::TBL_W-1:0];
        if (cmd.mul)
            prod_reg <= per_reg * lbb_pkg::SQ_TABLE[tidx_reg];
        if (cmd.out_load)
        begin
            osel_reg <= n_reg;
            opin_reg <= nv_reg & ~(pol_reg[n_reg] ^ lit_reg[n_reg]);
            olit_reg <= nv_reg & lit_reg[n_reg];
        end
    end

    assign stat.breath_go = ticking && (mode_reg[n_reg] == lbb_pkg::MODE_BREATH) &&
                            (total != '0) && (tc_new == '0);
    assign stat.div_busy  = div_busy;
    assign stat.div_done  = div_done;
    assign stat.m_zero    = (m_reg == '0);
    assign stat.out_free  = !ov_reg || !out_stall;

    assign out_valid = ov_reg;
    assign led_sel   = osel_reg;
    assign pin_level = opin_reg;
    assign lit       = olit_reg;
endmodule
`default_nettype wire

// File: rtl/lbb_ctrl.sv
// ============================================================================
// lbb_ctrl
// Sequencer: item execute, breath (two divides, multiply, write back), result.
// ============================================================================
`default_nettype none
module lbb_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                busy,
    input  wire lbb_pkg::stat_t stat,
    output lbb_pkg::cmd_t       cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DIV1 = 3'd2;
    localparam logic [2:0] S_CHKM = 3'd3;
    localparam logic [2:0] S_DIV2 = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_WB   = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       started_reg, started_next;

    always_comb
    begin
        state_next   = state_reg;
        started_next = started_reg;
        cmd          = '0;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec     = 1'b1;
                started_next = 1'b0;
                state_next   = stat.breath_go ? S_DIV1 : S_OUT;
            end
            S_DIV1, S_DIV2:
            begin
                cmd.div_sel = (state_reg == S_DIV2);
                if (!started_reg)
                begin
                    cmd.div_start = 1'b1;
                    started_next  = 1'b1;
                end
                else if (stat.div_done)
                begin
                    started_next = 1'b0;
                    if (state_reg == S_DIV1)
                    begin
                        cmd.cap_m  = 1'b1;
                        state_next = S_CHKM;
                    end
                    else
                    begin
                        cmd.cap_idx = 1'b1;
                        state_next  = S_MUL;
                    end
                end
            end
            S_CHKM: state_next = stat.m_zero ? S_OUT : S_DIV2;
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.wb     = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
endmodule
`default_nettype wire

// File: rtl/led_blink_breath_controller.sv
// Each accepted beat runs execute then result for static, blink and forced ops;
//   a breath tick at a wrap adds two 32-step serial divisions in the shared
//   divider, then multiply and write back; only the first when step count M is zero.
// A new beat is accepted only after the previous one has loaded its result.
// Reset: rst_n asynchronous, active low; LED state cleared, registers to defaults.
// ============================================================================
// led_blink_breath_controller
// Four-LED blink/breath controller with APB configuration registers.
// ============================================================================
`default_nettype none
`include "led_blink_breath_controller_defines.svh"
module led_blink_breath_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input beats
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  opcode,
    input  wire logic [1:0]  led_index,
    // result beats
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       led_sel,
    output logic             pin_level,
    output logic             lit,
    // APB
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    // Configuration registers, copied into an LED by a load opcode.
    logic [1:0]  mode_reg;
    logic        pol_reg;
    logic [15:0] on_reg, off_reg;
    logic [23:0] breath_reg;
    logic [2:0]  reg_sel;
    logic        wr_en;
    logic        busy;

    lbb_pkg::cmd_t  cmd;
    lbb_pkg::stat_t stat;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= lbb_pkg::MODE_STATIC;
            pol_reg    <= 1'b1;
            on_reg     <= 16'd5;
            off_reg    <= 16'd5;
            breath_reg <= 24'd1000;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                lbb_pkg::REG_MODE:   mode_reg   <= pwdata[1:0];
                lbb_pkg::REG_POL:    pol_reg    <= pwdata[0];
                lbb_pkg::REG_ON:     on_reg     <= pwdata[15:0];
                lbb_pkg::REG_OFF:    off_reg    <= pwdata[15:0];
                lbb_pkg::REG_BREATH: breath_reg <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            lbb_pkg::REG_MODE:   prdata = {30'd0, mode_reg};
            lbb_pkg::REG_POL:    prdata = {31'd0, pol_reg};
            lbb_pkg::REG_ON:     prdata = {16'd0, on_reg};
            lbb_pkg::REG_OFF:    prdata = {16'd0, off_reg};
            lbb_pkg::REG_BREATH: prdata = {8'd0, breath_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // Sequencer takes one beat at a time; a pending result does not block
    // acceptance, only the final result load.
    lbb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .busy     (busy),
        .stat     (stat),
        .cmd      (cmd)
    );

    assign in_stall = busy;

    lbb_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .opcode     (opcode),
        .led_index  (led_index),
        .cfg_mode   (mode_reg),
        .cfg_pol    (pol_reg),
        .cfg_on     (on_reg),
        .cfg_off    (off_reg),
        .cfg_breath (breath_reg),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .led_sel    (led_sel),
        .pin_level  (pin_level),
        .lit        (lit)
    );

    // accepted beat keeps the sequencer busy next cycle
    `LBB_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall)
    // divider only runs inside an item
    `LBB_ASSERT_IMPL(a_div_in_item, clk, rst_n, stat.div_busy, in_stall)
    // idle sequencer never produces a result in the following cycle
    `LBB_ASSERT_NEXT(a_no_spurious, clk, rst_n, !in_stall && (!out_valid || !out_stall), !out_valid)
endmodule
`default_nettype wire
